### src/hsvr_pkg.sv
// ----------------------------------------------------------------------------
// hsvr_pkg
// Types, segment codes and arithmetic helpers for the rainbow HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvr_pkg;

    // Rainbow segment picked by the top three hue bits
    typedef enum logic [2:0] {
        SEG_RED_ORANGE    = 3'd0,
        SEG_ORANGE_YELLOW = 3'd1,
        SEG_YELLOW_GREEN  = 3'd2,
        SEG_GREEN_AQUA    = 3'd3,
        SEG_AQUA_BLUE     = 3'd4,
        SEG_BLUE_PURPLE   = 3'd5,
        SEG_PURPLE_PINK   = 3'd6,
        SEG_PINK_RED      = 3'd7
    } seg_t;

    localparam logic [7:0] OFFS_MASK    = 8'h1F;
    localparam logic [7:0] K_THIRD      = 8'd85;
    localparam logic [7:0] K_170        = 8'd170;
    localparam logic [7:0] K_171        = 8'd171;
    localparam logic [7:0] K_FULL       = 8'd255;

    // Base color after segment decode, plus what later stages need
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] sat;
        logic [7:0] val;
        logic [7:0] dsq;
    } base_t;

    // Colors after saturation scaling
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] val;
        logic [7:0] dsq;
    } satd_t;

    // Final pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } rgbw_t;

    // (a * (b + 1)) >> 8; the product never exceeds 16 bits
    function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] prod;
        prod = {8'd0, a} * ({8'd0, b} + 16'd1);
        return prod[15:8];
    endfunction

    function automatic logic [7:0] add_sat8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8] ? K_FULL : sum[7:0];
    endfunction

endpackage

`default_nettype wire

### src/hsvr_if.sv
// ----------------------------------------------------------------------------
// hsvr_in_if / hsvr_out_if
// Valid/ready channels carrying an HSV pixel in and an RGBW pixel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue_in;
    logic [7:0] sat_in;
    logic [7:0] val_in;

    modport source (output valid, output hue_in, output sat_in, output val_in,
                    input ready);
    modport sink   (input valid, input hue_in, input sat_in, input val_in,
                    output ready);
endinterface

interface hsvr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] white_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output white_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input white_out, output ready);
endinterface

`default_nettype wire

### src/hsvr_base_stage.sv
// ----------------------------------------------------------------------------
// hsvr_base_stage
// Stage 1: rainbow segment decode and desaturation square.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_base_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     hue,
    input  wire logic [7:0]     sat,
    input  wire logic [7:0]     val,
    output logic                out_valid,
    input  wire logic           out_ready,
    output hsvr_pkg::base_t     out_data
);
    import hsvr_pkg::*;

    logic       valid_reg;
    base_t      data_reg;
    base_t      data_next;
    logic [7:0] offs;
    logic [7:0] third;
    logic [7:0] third_x2;
    logic [7:0] desat;

    assign offs       = (hue & OFFS_MASK) << 3;
    assign third      = scale8(offs, K_THIRD);
    assign third_x2   = scale8(offs, K_170);
    assign desat      = K_FULL - sat;

    always_comb
    begin
        data_next     = '0;
        data_next.sat = sat;
        data_next.val = val;
        data_next.dsq = scale8(desat, desat);
        case (seg_t'(hue[7:5]))
            SEG_RED_ORANGE:
            begin
                data_next.red   = K_FULL - third;
                data_next.green = third;
            end
            SEG_ORANGE_YELLOW:
            begin
                data_next.red   = K_171;
                data_next.green = K_THIRD + third;
            end
            SEG_YELLOW_GREEN:
            begin
                data_next.red   = K_171 - third_x2;
                data_next.green = K_170 + third;
            end
            SEG_GREEN_AQUA:
            begin
                data_next.green = K_FULL - third;
                data_next.blue  = third;
            end
            SEG_AQUA_BLUE:
            begin
                data_next.green = K_171 - third_x2;
                data_next.blue  = K_THIRD + third_x2;
            end
            SEG_BLUE_PURPLE:
            begin
                data_next.red   = third;
                data_next.blue  = K_FULL - third;
            end
            SEG_PURPLE_PINK:
            begin
                data_next.red   = K_THIRD + third;
                data_next.blue  = K_171 - third;
            end
            default:
            begin
                data_next.red   = K_170 + third;
                data_next.blue  = K_THIRD - third;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### src/hsvr_sat_stage.sv
// ----------------------------------------------------------------------------
// hsvr_sat_stage
// Stage 2: scale the base color by saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_sat_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hsvr_pkg::base_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output hsvr_pkg::satd_t     out_data
);
    import hsvr_pkg::*;

    logic  valid_reg;
    satd_t data_reg;
    satd_t data_next;

    always_comb
    begin
        data_next.red   = scale8(in_data.red,   in_data.sat);
        data_next.green = scale8(in_data.green, in_data.sat);
        data_next.blue  = scale8(in_data.blue,  in_data.sat);
        data_next.val   = in_data.val;
        data_next.dsq   = in_data.dsq;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### src/hsvr_val_stage.sv
// ----------------------------------------------------------------------------
// hsvr_val_stage
// Stage 3: add the white floor (saturating) and scale by value; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_val_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hsvr_pkg::satd_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output hsvr_pkg::rgbw_t     out_data
);
    import hsvr_pkg::*;

    logic  valid_reg;
    rgbw_t data_reg;
    rgbw_t data_next;

    always_comb
    begin
        data_next.red   = scale8(add_sat8(in_data.red,   in_data.dsq), in_data.val);
        data_next.green = scale8(add_sat8(in_data.green, in_data.dsq), in_data.val);
        data_next.blue  = scale8(add_sat8(in_data.blue,  in_data.dsq), in_data.val);
        // white base is zero, so the floor alone is scaled
        data_next.white = scale8(in_data.dsq, in_data.val);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### src/hsv_rainbow_to_rgb.sv
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb
// Rainbow HSV to RGBW pixel converter, three-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake     Payload
//  pix_in    in    valid/ready   hue_in, sat_in, val_in (8 bits each)
//  pix_out   out   valid/ready   red_out, green_out, blue_out, white_out
//
//  One transaction per clock sustained while pix_out is ready. Three
//  register stages (segment decode, saturation multiply, value multiply):
//  a result passes through them in order before it is valid on pix_out.
//  Reset clears the stage valid bits only; payload registers are not reset.
//  A stall on pix_out backs up only the stages that are full: empty stages
//  keep accepting, so pix_in.ready stays high while any bubble remains.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_rainbow_to_rgb (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hsvr_in_if.sink     pix_in,
    hsvr_out_if.source  pix_out
);
    import hsvr_pkg::*;

    // stage 1 -> stage 2
    logic  s1_valid;
    logic  s1_ready;
    base_t s1_data;

    // stage 2 -> stage 3
    logic  s2_valid;
    logic  s2_ready;
    satd_t s2_data;

    rgbw_t s3_data;

    // Segment decode: one third and double that of the hue offset build the
    // base color; the desaturation square is formed alongside.
    hsvr_base_stage u_base (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .hue       (pix_in.hue_in),
        .sat       (pix_in.sat_in),
        .val       (pix_in.val_in),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Saturation scaling of red, green and blue
    hsvr_sat_stage u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Saturating add of the white floor, value scaling; holds the result
    // until pix_out takes it
    hsvr_val_stage u_val (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_data  (s3_data)
    );

    assign pix_out.red_out   = s3_data.red;
    assign pix_out.green_out = s3_data.green;
    assign pix_out.blue_out  = s3_data.blue;
    assign pix_out.white_out = s3_data.white;

endmodule

`default_nettype wire

### src/hsvr_checker.sv
// ----------------------------------------------------------------------------
// hsvr_checker
// Port-level checks on the converter's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red_out,
    input wire logic [7:0] green_out,
    input wire logic [7:0] blue_out,
    input wire logic [7:0] white_out
);

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({red_out, green_out, blue_out, white_out}))
        else $error("result changed while stalled");

    // Empty output register means every stage can advance
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // A drained result frees the whole pipe
    a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input blocked while output drains");

    // Nothing appears without an earlier input transaction when never stalled
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid ##1 !in_valid ##1 !in_valid ##1 out_ready |=> !out_valid ||
            $past(out_valid))
        else $error("result appeared without input");

endmodule

bind hsv_rainbow_to_rgb hsvr_checker u_hsvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .red_out   (pix_out.red_out),
    .green_out (pix_out.green_out),
    .blue_out  (pix_out.blue_out),
    .white_out (pix_out.white_out)
);

`default_nettype wire

### verif/hsv_rainbow_to_rgb_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb_tb
// Self-checking bench for the rainbow HSV to RGBW converter. A scoreboard
// class predicts each pixel from the accepted HSV transaction and checks the
// RGBW results in order. The sender works in bursts, and the receiver stalls
// on a pattern of its own, with one long hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_rainbow_to_rgb_tb;

    import hsvr_pkg::*;

    localparam int N_RANDOM     = 900;
    localparam int HOLD_CYCLES  = 64;   // long receiver hold-off
    localparam int HOLD_AT      = 250;  // input count that triggers it
    localparam int SOLID_FIRST  = 200;  // random items sent with no gaps
    localparam int SOLID_LAST   = 500;
    localparam int DRAIN_AT     = 650;  // mid-run drain point
    localparam int TAIL_CYCLES  = 10;   // pipeline is three deep

    // ------------------------------------------------------------------------
    // Expected-pixel tracker: predicts RGBW from HSV and checks in order
    // ------------------------------------------------------------------------
    class pixel_tracker;
        rgbw_t pending_rgbw[$];
        int    mismatches;

        function new();
            mismatches = 0;
        endfunction

        // (a * (b + 1)) / 256
        static function logic [7:0] frac_mul(input logic [7:0] a, input logic [7:0] b);
            int unsigned prod;
            prod = int'(a) * (int'(b) + 1);
            return 8'(prod >> 8);
        endfunction

        static function rgbw_t rainbow_rgbw(input logic [7:0] hue, input logic [7:0] sat,
                                            input logic [7:0] val);
            logic [7:0]  offs;
            logic [7:0]  third;
            logic [7:0]  two3;
            logic [7:0]  base [4];
            logic [7:0]  desat_sq;
            int unsigned lvl;
            rgbw_t       px;
            seg_t        seg;

            offs  = (hue & OFFS_MASK) << 3;
            third = frac_mul(offs, K_THIRD);
            two3  = frac_mul(offs, K_170);
            seg   = seg_t'(hue[7:5]);
            case (seg)
                SEG_RED_ORANGE:    begin base[0] = K_FULL - third; base[1] = third;
                                         base[2] = 8'd0; end
                SEG_ORANGE_YELLOW: begin base[0] = K_171; base[1] = K_THIRD + third;
                                         base[2] = 8'd0; end
                SEG_YELLOW_GREEN:  begin base[0] = K_171 - two3; base[1] = K_170 + third;
                                         base[2] = 8'd0; end
                SEG_GREEN_AQUA:    begin base[0] = 8'd0; base[1] = K_FULL - third;
                                         base[2] = third; end
                SEG_AQUA_BLUE:     begin base[0] = 8'd0; base[1] = K_171 - two3;
                                         base[2] = K_THIRD + two3; end
                SEG_BLUE_PURPLE:   begin base[0] = third; base[1] = 8'd0;
                                         base[2] = K_FULL - third; end
                SEG_PURPLE_PINK:   begin base[0] = K_THIRD + third; base[1] = 8'd0;
                                         base[2] = K_171 - third; end
                default:           begin base[0] = K_170 + third; base[1] = 8'd0;
                                         base[2] = K_THIRD - third; end
            endcase
            base[3] = 8'd0;

            desat_sq = frac_mul(K_FULL - sat, K_FULL - sat);
            for (int i = 0; i < 4; i++)
            begin
                lvl = int'(frac_mul(base[i], sat)) + int'(desat_sq);
                if (lvl > 255)
                    lvl = 255;
                base[i] = frac_mul(lvl[7:0], val);
            end
            px.red   = base[0];
            px.green = base[1];
            px.blue  = base[2];
            px.white = base[3];
            return px;
        endfunction

        function void note_hsv(input logic [7:0] hue, input logic [7:0] sat,
                               input logic [7:0] val);
            pending_rgbw.push_back(rainbow_rgbw(hue, sat, val));
        endfunction

        function void report(input string field, input logic [7:0] want,
                             input logic [7:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        endfunction

        function void check_rgbw(input rgbw_t got);
            rgbw_t want;
            if (pending_rgbw.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
                return;
            end
            want = pending_rgbw.pop_front();
            if (got.red !== want.red)
                report("red", want.red, got.red);
            if (got.green !== want.green)
                report("green", want.green, got.green);
            if (got.blue !== want.blue)
                report("blue", want.blue, got.blue);
            if (got.white !== want.white)
                report("white", want.white, got.white);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    hsvr_in_if  pix_in_bus ();
    hsvr_out_if pix_out_bus ();

    hsv_rainbow_to_rgb uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus)
    );

    pixel_tracker tracker = new();
    int           pixels_in = 0;   // accepted input transactions so far

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Every DUT input gets a known value at time zero
    initial
    begin
        rst_n                 <= 1'b0;
        pix_in_bus.valid      <= 1'b0;
        pix_in_bus.hue_in     <= 8'd0;
        pix_in_bus.sat_in     <= 8'd0;
        pix_in_bus.val_in     <= 8'd0;
        pix_out_bus.ready     <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Monitors: sample both channels at the clock edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pix_in_bus.valid && pix_in_bus.ready)
        begin
            tracker.note_hsv(pix_in_bus.hue_in, pix_in_bus.sat_in, pix_in_bus.val_in);
            pixels_in <= pixels_in + 1;
        end
    end

    always @(posedge clk)
    begin
        rgbw_t got;
        if (rst_n && pix_out_bus.valid && pix_out_bus.ready)
        begin
            got.red   = pix_out_bus.red_out;
            got.green = pix_out_bus.green_out;
            got.blue  = pix_out_bus.blue_out;
            got.white = pix_out_bus.white_out;
            tracker.check_rgbw(got);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. valid is only lowered by idle_sender and drain_pipeline, so
    // back-to-back transactions never see a low/high pair in one time step.
    // ------------------------------------------------------------------------
    task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] val);
        pix_in_bus.valid  <= 1'b1;
        pix_in_bus.hue_in <= hue;
        pix_in_bus.sat_in <= sat;
        pix_in_bus.val_in <= val;
        @(posedge clk);
        while (!pix_in_bus.ready)
            @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        pix_in_bus.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted pixel has come back
    task automatic drain_pipeline();
        pix_in_bus.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_rgbw.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Mostly uniform, with the field extremes showing up now and then
    function automatic logic [7:0] pick_field();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: its own stall pattern, plus one long hold-off once the
    // sender is in its gap-free stretch so the pipeline backs up into pix_in
    // ------------------------------------------------------------------------
    initial
    begin
        bit held_off;
        int span;
        held_off = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_off && pixels_in >= HOLD_AT)
            begin
                held_off = 1'b1;
                pix_out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                span = $urandom_range(4, 30);
                case ($urandom_range(0, 3))
                    0:  // free running
                    begin
                        pix_out_bus.ready <= 1'b1;
                        repeat (span) @(posedge clk);
                    end
                    1:  // coin flip each cycle
                        repeat (span)
                        begin
                            pix_out_bus.ready <= 1'($urandom_range(0, 1));
                            @(posedge clk);
                        end
                    2:  // short stall
                    begin
                        pix_out_bus.ready <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge clk);
                    end
                    default:  // alternate every cycle
                        repeat (span)
                        begin
                            pix_out_bus.ready <= ~pix_out_bus.ready;
                            @(posedge clk);
                        end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] dir_hsv [25][3];
        int burst_left;

        // Segment boundaries at full color, then desaturation, value and
        // mid-range corners
        dir_hsv = '{
            '{8'd0,   8'd255, 8'd255}, '{8'd31,  8'd255, 8'd255},
            '{8'd32,  8'd255, 8'd255}, '{8'd63,  8'd255, 8'd255},
            '{8'd64,  8'd255, 8'd255}, '{8'd95,  8'd255, 8'd255},
            '{8'd96,  8'd255, 8'd255}, '{8'd127, 8'd255, 8'd255},
            '{8'd128, 8'd255, 8'd255}, '{8'd159, 8'd255, 8'd255},
            '{8'd160, 8'd255, 8'd255}, '{8'd191, 8'd255, 8'd255},
            '{8'd192, 8'd255, 8'd255}, '{8'd223, 8'd255, 8'd255},
            '{8'd224, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255},
            '{8'd100, 8'd0,   8'd255}, '{8'd100, 8'd0,   8'd0},
            '{8'd0,   8'd1,   8'd255}, '{8'd255, 8'd16,  8'd255},
            '{8'd200, 8'd128, 8'd128}, '{8'd77,  8'd255, 8'd0},
            '{8'd45,  8'd17,  8'd1},   '{8'd160, 8'd254, 8'd254},
            '{8'd127, 8'd0,   8'd1}
        };

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        foreach (dir_hsv[i])
        begin
            send_pixel(dir_hsv[i][0], dir_hsv[i][1], dir_hsv[i][2]);
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 4));
        end
        drain_pipeline();

        // Random bursts; the middle stretch runs gap-free to meet the hold-off
        burst_left = $urandom_range(1, 30);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == DRAIN_AT)
                drain_pipeline();
            send_pixel(pick_field(), pick_field(), pick_field());
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 30);
                if (n < SOLID_FIRST || n > SOLID_LAST)
                    idle_sender($urandom_range(1, 8));
            end
        end

        drain_pipeline();
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
